### design/hdu_pkg.sv
// ============================================================================
// hdu_pkg: shared constants and tables for the haversine distance unit
// Fixed-point formats, CORDIC arctangent table, divider and scaling constants.
// ============================================================================
package hdu_pkg;

  localparam int ANGLE_FRAC_BITS = 23;
  localparam int DIST_FRAC_BITS  = 4;

  // Input channel field widths
  localparam int LAT_W = 31;
  localparam int LON_W = 32;

  // Degree difference width and phase width (2^32 = one turn)
  localparam int DIFF_W  = 33;
  localparam int PHASE_W = 32;

  // Degree to phase: round(d * 2^(32-F) / 720) = floor((|d|*2^HALF_SH + 22) / 45)
  localparam int HALF_SH   = 32 - ANGLE_FRAC_BITS - 4;
  localparam int FULL_SH   = 32 - ANGLE_FRAC_BITS - 3;
  localparam int ROUND_ADD = 22;
  localparam int NUM_W     = DIFF_W + FULL_SH + 1;
  localparam int DIV_BYTES = (NUM_W + 7) / 8;
  localparam int DIV_K        = 45;
  localparam int REM_W        = 6;
  localparam int DIV_RECIP    = 23302;   // ceil(2^20 / 45)
  localparam int DIV_RECIP_SH = 20;

  // CORDIC
  localparam int CORDIC_STEPS = 30;
  localparam int CS_W         = 34;
  localparam int AT_W         = 36;
  localparam int ZW           = 34;
  localparam int GAIN_Q30     = 652032874;
  localparam int TRIG_W       = 32;

  // Haversine arithmetic
  localparam int H_W          = 34;
  localparam int HQ_W         = 31;
  localparam longint ONE_Q30  = 64'd1073741824;

  // Integer square root
  localparam int SQRT_STEPS = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;

  // Distance scaling
  localparam longint FOUR_PI_R_Q4 = 64'd1281326976;
  localparam int     DIST_W       = 29;
  localparam longint DIST_MAX     = 64'd536870911;
  localparam longint QUARTER_TURN = 64'd1073741824;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

### design/haversine_distance_unit.sv
// ============================================================================
// haversine_distance_unit: great-circle distance between two points
// Haversine formula on a fixed-radius sphere, fully pipelined.
// ============================================================================
// Usage:
//   Slave channel in_*: one transaction carries two points (latitude and
//   longitude in signed degrees, 23 fraction bits). Master channel out_*:
//   one transaction per input, the distance in meters with 4 fraction bits.
//   Results leave in the order the points arrived.
// Datapath: input register, degree-to-phase divider, sin/cos CORDIC,
//   haversine products, square root, arctangent CORDIC, distance scaling.
// Throughput: one transaction per cycle while in_tready is high. Every stage register carries a
//   valid bit; bubbles move through like items.
// Stall: the whole pipeline advances while the output register is empty or
//   being taken (in_tready = !out_tvalid | out_tready). When the receiver
//   holds off, every stage freezes in place; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits. The block
//   holds no other state and needs no setup.
// Out-of-range angles wrap modulo 360 degrees; the haversine sum is clamped
//   to [0, 1] and the distance saturates at the 29-bit maximum.
// ============================================================================
module haversine_distance_unit import hdu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // from_lat[30:0], from_lon[62:31], to_lat[93:63],
                                   // to_lon[125:94], zero pad[127:126]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // distance_m[28:0], zero pad[31:29]
);

  logic pipe_en;

  // Input field unpack
  logic signed [LAT_W-1:0] from_lat, to_lat;
  logic signed [LON_W-1:0] from_lon, to_lon;

  assign from_lat = in_tdata[30:0];
  assign from_lon = in_tdata[62:31];
  assign to_lat   = in_tdata[93:63];
  assign to_lon   = in_tdata[125:94];

  // Input register: differences and sign-extended latitudes
  logic                     in_vld_r;
  logic signed [DIFF_W-1:0] dlat_r, dlon_r, lat1_r, lat2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (pipe_en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dlat_r <= DIFF_W'(from_lat) - DIFF_W'(to_lat);
      dlon_r <= DIFF_W'(from_lon) - DIFF_W'(to_lon);
      lat1_r <= DIFF_W'(from_lat);
      lat2_r <= DIFF_W'(to_lat);
    end
  end

  // Degree to phase (half angles for the differences, full for the latitudes)
  logic               ph_vld;
  logic [PHASE_W-1:0] ph_dlat, ph_dlon, ph_lat1, ph_lat2;

  hdu_deg2phase u_ph_dlat (
    .clk, .rst_n, .en(pipe_en), .vld_i(in_vld_r), .half_i(1'b1),
    .deg_i(dlat_r), .vld_o(ph_vld), .phase_o(ph_dlat)
  );
  hdu_deg2phase u_ph_dlon (
    .clk, .rst_n, .en(pipe_en), .vld_i(in_vld_r), .half_i(1'b1),
    .deg_i(dlon_r), .vld_o(), .phase_o(ph_dlon)
  );
  hdu_deg2phase u_ph_lat1 (
    .clk, .rst_n, .en(pipe_en), .vld_i(in_vld_r), .half_i(1'b0),
    .deg_i(lat1_r), .vld_o(), .phase_o(ph_lat1)
  );
  hdu_deg2phase u_ph_lat2 (
    .clk, .rst_n, .en(pipe_en), .vld_i(in_vld_r), .half_i(1'b0),
    .deg_i(lat2_r), .vld_o(), .phase_o(ph_lat2)
  );

  // Sine of half differences, cosine of latitudes
  logic                     tr_vld;
  logic signed [TRIG_W-1:0] s_dlat, s_dlon, c_lat1, c_lat2;

  hdu_sincos u_sc_dlat (
    .clk, .rst_n, .en(pipe_en), .vld_i(ph_vld), .phase_i(ph_dlat),
    .vld_o(tr_vld), .sin_o(s_dlat), .cos_o()
  );
  hdu_sincos u_sc_dlon (
    .clk, .rst_n, .en(pipe_en), .vld_i(ph_vld), .phase_i(ph_dlon),
    .vld_o(), .sin_o(s_dlon), .cos_o()
  );
  hdu_sincos u_sc_lat1 (
    .clk, .rst_n, .en(pipe_en), .vld_i(ph_vld), .phase_i(ph_lat1),
    .vld_o(), .sin_o(), .cos_o(c_lat1)
  );
  hdu_sincos u_sc_lat2 (
    .clk, .rst_n, .en(pipe_en), .vld_i(ph_vld), .phase_i(ph_lat2),
    .vld_o(), .sin_o(), .cos_o(c_lat2)
  );

  // Stage 1: squares and cosine product
  logic                           v1_r;
  logic signed [2*TRIG_W-1:0]     sq_lat_r, sq_lon_r, cc_r;

  // Stage 2: rescale to Q30
  logic                           v2_r;
  logic signed [H_W-1:0]          lat_h_r, lon_h_r, prod_r;

  // Stage 3: cos*cos*sin^2 term
  logic                           v3_r;
  logic signed [H_W-1:0]          lat_h3_r;
  logic signed [2*H_W-1:0]        pl_r;

  // Stage 4: haversine sum, clamped to [0, 1]
  logic                           v4_r;
  logic [HQ_W-1:0]                h_r, hc_r;
  logic signed [2*H_W-1:0]        hsum;
  logic [HQ_W-1:0]                h_nxt;

  always_comb begin
    hsum = (2*H_W)'(lat_h3_r) + (pl_r >>> 30);
    priority if (hsum < 0) begin
      h_nxt = '0;
    end else if (hsum > (2*H_W)'(ONE_Q30)) begin
      h_nxt = HQ_W'(ONE_Q30);
    end else begin
      h_nxt = hsum[HQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= tr_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_lat_r <= s_dlat * s_dlat;
      sq_lon_r <= s_dlon * s_dlon;
      cc_r     <= c_lat1 * c_lat2;
      lat_h_r  <= H_W'(sq_lat_r >>> 30);
      lon_h_r  <= H_W'(sq_lon_r >>> 30);
      prod_r   <= H_W'(cc_r >>> 30);
      lat_h3_r <= lat_h_r;
      pl_r     <= prod_r * lon_h_r;
      h_r      <= h_nxt;
      hc_r     <= HQ_W'(ONE_Q30) - h_nxt;
    end
  end

  // Roots of h and 1-h
  logic              rt_vld;
  logic [ROOT_W-1:0] root_a, root_b;

  hdu_isqrt u_sqrt_a (
    .clk, .rst_n, .en(pipe_en), .vld_i(v4_r),
    .n_i(SQ_W'(h_r) << 30), .vld_o(rt_vld), .root_o(root_a)
  );
  hdu_isqrt u_sqrt_b (
    .clk, .rst_n, .en(pipe_en), .vld_i(v4_r),
    .n_i(SQ_W'(hc_r) << 30), .vld_o(), .root_o(root_b)
  );

  // Arc angle = atan2(sqrt(h), sqrt(1-h))
  logic                 z_vld;
  logic signed [ZW-1:0] z_arc;

  hdu_atan u_atan (
    .clk, .rst_n, .en(pipe_en), .vld_i(rt_vld),
    .y_i(root_a), .x_i(root_b), .vld_o(z_vld), .z_o(z_arc)
  );

  // Stage 5: clamp arc angle to a quarter turn, scale by 4*pi*R
  logic          v5_r;
  logic [30:0]   zc;
  logic [61:0]   mul_r;

  always_comb begin
    priority if (z_arc < 0) begin
      zc = '0;
    end else if (z_arc > ZW'(QUARTER_TURN)) begin
      zc = 31'(QUARTER_TURN);
    end else begin
      zc = z_arc[30:0];
    end
  end

  // Stage 6: round, drop extra fraction bits, saturate
  logic                out_vld_r;
  logic [DIST_W-1:0]   dist_r;
  logic [62:0]         dsum;
  logic [62:0]         dq;
  logic [DIST_W-1:0]   dist_nxt;

  always_comb begin
    dsum = 63'(mul_r) + (63'(1) << (35 - DIST_FRAC_BITS));
    dq   = dsum >> (36 - DIST_FRAC_BITS);
    dist_nxt = (dq > 63'(DIST_MAX)) ? DIST_W'(DIST_MAX) : dq[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      v5_r      <= z_vld;
      out_vld_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mul_r  <= 62'(zc) * 62'(FOUR_PI_R_Q4);
      dist_r <= dist_nxt;
    end
  end

  // Global advance: output register empty or being drained
  assign pipe_en    = !out_vld_r || out_tready;
  assign in_tready  = pipe_en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, dist_r};

`ifndef ASSERT_OFF
  a_h_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (h_r <= HQ_W'(ONE_Q30)) && (32'(h_r) + 32'(hc_r) == 32'(ONE_Q30)))
    else $error("haversine sum out of [0,1] or complement mismatch");

  a_arc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (mul_r <= 62'(QUARTER_TURN) * 62'(FOUR_PI_R_Q4)))
    else $error("scaled arc exceeds quarter turn");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(h_r) && $stable(v4_r) && $stable(z_arc))
    else $error("pipeline moved during output stall");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (dist_r <= DIST_W'(320331862)))
    else $error("distance beyond half circumference");
`endif

endmodule

### design/hdu_deg2phase.sv
// ============================================================================
// hdu_deg2phase: degrees to turn-unit phase
// Rounds half away from zero; divides by 45 one byte per pipeline stage.
// ============================================================================
module hdu_deg2phase import hdu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic                     half_i,
  input  logic signed [DIFF_W-1:0] deg_i,
  output logic                     vld_o,
  output logic [PHASE_W-1:0]       phase_o
);

  localparam int NW = DIV_BYTES * 8;

  logic [DIFF_W-1:0] mag;
  logic [NW-1:0]     num_nxt;

  logic              vld_r [0:DIV_BYTES];
  logic              neg_r [0:DIV_BYTES];
  logic [NW-1:0]     num_r [0:DIV_BYTES];
  logic [REM_W-1:0]  rem_r [0:DIV_BYTES];
  logic [NW-1:0]     quo_r [0:DIV_BYTES];
  logic              out_vld_r;
  logic [PHASE_W-1:0] phase_r;

  always_comb begin
    mag     = deg_i[DIFF_W-1] ? DIFF_W'(-deg_i) : DIFF_W'(deg_i);
    num_nxt = (half_i ? (NW'(mag) << HALF_SH) : (NW'(mag) << FULL_SH)) + NW'(ROUND_ADD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= num_nxt;
      neg_r[0] <= deg_i[DIFF_W-1];
      rem_r[0] <= '0;
      quo_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < DIV_BYTES; g++) begin : g_div
    logic [REM_W+7:0]  x;
    logic [REM_W+22:0] xr;
    logic [7:0]        qd;
    logic [REM_W+7:0]  rem_n;

    always_comb begin
      x     = {rem_r[g], num_r[g][NW-1-8*g -: 8]};
      xr    = (REM_W+23)'(x) * (REM_W+23)'(DIV_RECIP);
      qd    = xr[DIV_RECIP_SH +: 8];
      rem_n = x - (REM_W+8)'(qd) * (REM_W+8)'(DIV_K);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g+1] <= num_r[g];
        neg_r[g+1] <= neg_r[g];
        rem_r[g+1] <= rem_n[REM_W-1:0];
        quo_r[g+1] <= {quo_r[g][NW-9:0], qd};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[DIV_BYTES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= neg_r[DIV_BYTES] ? PHASE_W'(-quo_r[DIV_BYTES][PHASE_W-1:0])
                                  : quo_r[DIV_BYTES][PHASE_W-1:0];
    end
  end

  assign vld_o   = out_vld_r;
  assign phase_o = phase_r;

endmodule

### design/hdu_sincos.sv
// ============================================================================
// hdu_sincos: pipelined rotation-mode CORDIC
// One micro-rotation per stage; quadrant fold on entry, sign fix on exit.
// ============================================================================
module hdu_sincos import hdu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic [PHASE_W-1:0]       phase_i,
  output logic                     vld_o,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic                    neg;
  logic [PHASE_W-1:0]      p;

  logic                    vld_r [0:CORDIC_STEPS];
  logic                    neg_r [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  x_r   [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  y_r   [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  z_r   [0:CORDIC_STEPS];
  logic                    out_vld_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  always_comb begin
    neg = (phase_i[31:30] == 2'd1) || (phase_i[31:30] == 2'd2);
    p   = neg ? phase_i + 32'h8000_0000 : phase_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= neg;
      x_r[0]   <= CS_W'(GAIN_Q30);
      y_r[0]   <= '0;
      z_r[0]   <= {{(CS_W-PHASE_W){p[PHASE_W-1]}}, p};
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    logic signed [CS_W-1:0] xs, ys, at;

    always_comb begin
      xs = x_r[g] >>> g;
      ys = y_r[g] >>> g;
      at = CS_W'(atan_turn(5'(g)));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[g+1] <= neg_r[g];
        if (!z_r[g][CS_W-1]) begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - at;
        end else begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= neg_r[CORDIC_STEPS] ? TRIG_W'(-y_r[CORDIC_STEPS]) : TRIG_W'(y_r[CORDIC_STEPS]);
      cos_r <= neg_r[CORDIC_STEPS] ? TRIG_W'(-x_r[CORDIC_STEPS]) : TRIG_W'(x_r[CORDIC_STEPS]);
    end
  end

  assign vld_o = out_vld_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### design/hdu_isqrt.sv
// ============================================================================
// hdu_isqrt: pipelined bitwise integer square root
// One result bit per stage, 64-bit radicand.
// ============================================================================
module hdu_isqrt import hdu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o
);

  logic            vld_r [0:SQRT_STEPS];
  logic [SQ_W-1:0] n_r   [0:SQRT_STEPS];
  logic [SQ_W-1:0] r_r   [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= n_i;
      r_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_bit
    logic [SQ_W-1:0] b, t;

    always_comb begin
      b = SQ_W'(1) << (SQ_W - 2 - 2*g);
      t = r_r[g] + b;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_r[g] >= t) begin
          n_r[g+1] <= n_r[g] - t;
          r_r[g+1] <= (r_r[g] >> 1) + b;
        end else begin
          n_r[g+1] <= n_r[g];
          r_r[g+1] <= r_r[g] >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_r[SQRT_STEPS];
  assign root_o = r_r[SQRT_STEPS][ROOT_W-1:0];

endmodule

### design/hdu_atan.sv
// ============================================================================
// hdu_atan: pipelined vectoring-mode CORDIC
// Angle of (x, y) in turn units, one micro-rotation per stage.
// ============================================================================
module hdu_atan import hdu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [ROOT_W-1:0]    y_i,
  input  logic [ROOT_W-1:0]    x_i,
  output logic                 vld_o,
  output logic signed [ZW-1:0] z_o
);

  logic                   vld_r [0:CORDIC_STEPS];
  logic signed [AT_W-1:0] x_r   [0:CORDIC_STEPS];
  logic signed [AT_W-1:0] y_r   [0:CORDIC_STEPS];
  logic signed [ZW-1:0]   z_r   [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= AT_W'(x_i);
      y_r[0] <= AT_W'(y_i);
      z_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    logic signed [AT_W-1:0] xs, ys;
    logic signed [ZW-1:0]   at;

    always_comb begin
      xs = x_r[g] >>> g;
      ys = y_r[g] >>> g;
      at = ZW'(atan_turn(5'(g)));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[g][AT_W-1]) begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + at;
        end else begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - at;
        end
      end
    end
  end

  assign vld_o = vld_r[CORDIC_STEPS];
  assign z_o   = z_r[CORDIC_STEPS];

endmodule

### verif/tb_top.sv
// ============================================================================
// tb_top: stream checker for the haversine distance unit
// Drives point pairs on the input channel, predicts each distance with a
// bit-true model of the CORDIC/root datapath, and checks results in order.
// ============================================================================
module tb_top import hdu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PIPE_LAT   = 110;
  localparam int  N_RANDOM   = 900;
  localparam longint LIMIT   = 400000;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // from_lat, from_lon, to_lat, to_lon, pad (low bit up)
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;   // distance_m, pad (low bit up)

  haversine_distance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Expected distances, oldest first.
  logic [28:0] dist_queue[$];
  int          n_fail;
  bit          stim_done;
  bit          hold_rx;     // long receiver hold-off
  longint      cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---- predictor -----------------------------------------------------------
  const longint arctab[30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  // Degrees (23 frac bits) to turn phase, round half away from zero, mod 2^32.
  function automatic logic [31:0] phase_of(longint d, longint div);
    longint num, q;
    num = d * (longint'(1) << (32 - ANGLE_FRAC_BITS));
    if (num >= 0) q = (num + div / 2) / div;
    else q = -((-num + div / 2) / div);
    return q[31:0];
  endfunction

  // Rotation-mode CORDIC; >>> on longint is floor division by 2^i.
  function automatic void sin_cos(input logic [31:0] p, output longint s,
                                  output longint c);
    logic [31:0] pp;
    bit          flip;
    longint      x, y, z, xs, ys;
    pp = p;
    flip = (pp[31:30] == 2'd1) || (pp[31:30] == 2'd2);
    if (flip) pp = pp + 32'h80000000;
    x = 652032874; y = 0;
    z = longint'($signed(pp));
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctab[i];
      end else begin
        x += ys; y -= xs; z += arctab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [28:0] great_circle(longint la1, longint lo1,
                                               longint la2, longint lo2);
    longint s, c, c1, c2, lat_h, lon_h, prod, h, x, y, z, xs, ys;
    longint unsigned a, b, d;
    sin_cos(phase_of(la1 - la2, 720), s, c);
    lat_h = (s * s) >>> 30;
    sin_cos(phase_of(lo1 - lo2, 720), s, c);
    lon_h = (s * s) >>> 30;
    sin_cos(phase_of(la1, 360), s, c1);
    sin_cos(phase_of(la2, 360), s, c2);
    prod = (c1 * c2) >>> 30;
    h = lat_h + ((prod * lon_h) >>> 30);
    if (h < 0) h = 0;
    if (h > ONE_Q30) h = ONE_Q30;
    a = int_root(longint'(h) << 30);
    b = int_root(longint'(ONE_Q30 - h) << 30);
    // vectoring-mode arctangent
    y = a; x = b; z = 0;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctab[i];
      end else begin
        x -= ys; y += xs; z -= arctab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_TURN) z = QUARTER_TURN;
    d = (longint'(z) * FOUR_PI_R_Q4 + (64'd1 << (35 - DIST_FRAC_BITS)))
        >> (36 - DIST_FRAC_BITS);
    if (d > DIST_MAX) d = DIST_MAX;
    return d[28:0];
  endfunction

  // ---- directed table ------------------------------------------------------
  // exp < 0: predictor only. Even a repeated point leaves a few units of
  // CORDIC residue in the arc angle, so these rows all go to the predictor.
  typedef struct {
    longint la1, lo1, la2, lo2;
    longint exp;
  } pair_row_t;

  localparam int N_DIR = 16;
  localparam longint DEG = 64'd1 << ANGLE_FRAC_BITS;
  pair_row_t dir_tab[N_DIR] = '{
    '{0, 0, 0, 0, -1},                        // same point
    '{LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, -1},
    '{-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, -1},
    '{LAT_MAX, 0, -LAT_MAX, 0, -1},           // pole to pole
    '{0, 0, 0, 180 * DEG, -1},                // antipodal on equator
    '{0, -LON_MAX, 0, LON_MAX, -1},
    '{-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, -1},
    '{0, 0, 0, 1, -1},                        // one lsb apart
    '{0, 0, 1, 0, -1},
    '{45 * DEG, 10 * DEG, -30 * DEG, 100 * DEG, -1},
    '{-(64'd1 << 30), -(64'd1 << 31), 64'h3FFFFFFF, 64'h7FFFFFFF, -1}, // raw field extremes
    '{64'h3FFFFFFF, 64'h7FFFFFFF, -(64'd1 << 30), -(64'd1 << 31), -1},
    '{0, 0, 0, 360 * DEG, -1},                // wrap
    '{89 * DEG, 0, 89 * DEG, 179 * DEG, -1},
    '{10 * DEG, 20 * DEG, 10 * DEG + 5, 20 * DEG - 7, -1},
    '{-60 * DEG, -120 * DEG, 60 * DEG, 60 * DEG, -1}
  };

  // ---- sender --------------------------------------------------------------
  task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2,
                           bit calm);
    while (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, lo2[31:0], la2[30:0], lo1[31:0], la1[30:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic longint raw_field(int w);
    logic [31:0] r;
    r = $urandom();
    return (w == 31) ? longint'($signed(r[30:0])) : longint'($signed(r));
  endfunction

  initial begin
    longint la1, lo1, la2, lo2;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    stim_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_pair(dir_tab[i].la1, dir_tab[i].lo1, dir_tab[i].la2, dir_tab[i].lo2, 1'b1);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(9))
        0: begin   // any bit pattern, wrapping angles
          la1 = raw_field(31); lo1 = raw_field(32);
          la2 = raw_field(31); lo2 = raw_field(32);
        end
        1: begin   // nearby points
          la1 = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
          lo1 = longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
          la2 = la1 + $urandom_range(2000) - 1000;
          lo2 = lo1 + $urandom_range(2000) - 1000;
        end
        2: begin   // near antipodal
          la1 = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
          lo1 = longint'($urandom_range(LON_MAX));
          la2 = -la1 + $urandom_range(20) - 10;
          lo2 = lo1 - LON_MAX + $urandom_range(20) - 10;
        end
        default: begin
          la1 = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
          lo1 = longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
          la2 = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
          lo2 = longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
        end
      endcase
      // stretch of steady input around the middle of the run
      send_pair(la1, lo1, la2, lo2, (n >= 300 && n < 450));
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      dist_queue.insert(dist_queue.size(), great_circle(
        longint'($signed(in_tdata[30:0])),  longint'($signed(in_tdata[62:31])),
        longint'($signed(in_tdata[93:63])), longint'($signed(in_tdata[125:94]))));
    end
  end

  // ---- receiver ------------------------------------------------------------
  // Long hold-off: wait until some traffic has flowed, then hold out_tready low.
  initial begin
    hold_rx = 1'b0;
    wait (rst_n);
    repeat (600) @(posedge clk);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else if (cycle_cnt > 2000 && cycle_cnt < 3000) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 13);
    end
  end

  // Check each output transaction against the oldest expected distance.
  always @(posedge clk) begin
    logic [28:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (dist_queue.size() == 0) begin
        $error("distance_m: unexpected result %0d", out_tdata[28:0]);
        n_fail++;
      end else begin
        want = dist_queue.pop_front();
        if (out_tdata[28:0] !== want) begin
          $error("distance_m: expected %0d actual %0d", want, out_tdata[28:0]);
          n_fail++;
        end
        if (out_tdata[31:29] !== 3'b000) begin
          $error("pad: expected 0 actual %0d", out_tdata[31:29]);
          n_fail++;
        end
      end
    end
  end

  // Spot-check the rows with a typed-in distance, in order.
  int dir_seen;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && dir_seen < N_DIR) begin
      if (dir_tab[dir_seen].exp >= 0 && out_tdata[28:0] !== dir_tab[dir_seen].exp[28:0]) begin
        $error("distance_m: expected %0d actual %0d", dir_tab[dir_seen].exp,
               out_tdata[28:0]);
        n_fail++;
      end
      dir_seen++;
    end
  end

  // ---- end of run ----------------------------------------------------------
  initial begin
    n_fail    = 0;
    dir_seen  = 0;
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (dist_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (n_fail == 0 && dist_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
